// ----- rtl/core/kst_pkg.sv -----
// ----------------------------------------------------------------------------
// kst_pkg
// shared types, sizes and codes of the key slot table
// ----------------------------------------------------------------------------
`default_nettype none

package kst_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 16;
   localparam int SLOT_W      = 6;

   typedef enum logic [1:0] {
      OP_GET = 2'd0,
      OP_ADD = 2'd1,
      OP_DEL = 2'd2,
      OP_CLR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef struct packed {
      op_type            operation;
      logic [KEY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              hit;
      status_type        status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } kst_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
   } kst_stat_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SCAN   = 2'd1,
      S_COMMIT = 2'd2
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/kst_ctrl.sv -----
// ----------------------------------------------------------------------------
// kst_ctrl
// sequencer: takes a request, runs the table scan, then commits the update
// ----------------------------------------------------------------------------
`default_nettype none

module kst_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  kst_pkg::kst_stat_type stat,
   output kst_pkg::kst_cmd_type  cmd
);
   import kst_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.commit = 1'b0;
      busy       = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.step = 1'b1;
            if (stat.scan_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/kst_dpath.sv -----
// ----------------------------------------------------------------------------
// kst_dpath
// key memory, valid bits, entry count, scan pipeline and result register
// ----------------------------------------------------------------------------
`default_nettype none

module kst_dpath (
   input  wire                   clock,
   input  wire                   reset,
   input  kst_pkg::req_type      req_data,
   input  kst_pkg::kst_cmd_type  cmd,
   output kst_pkg::kst_stat_type stat,
   output logic                  rsp_valid,
   output kst_pkg::rsp_type      rsp_data
);
   import kst_pkg::*;

   logic [KEY_W-1:0]       mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [CNT_W-1:0]       count_ff;

   op_type                 op_ff;
   logic [KEY_W-1:0]       key_ff;

   // scan: address stage then compare stage
   logic [CNT_W-1:0]       addr_ff;
   logic                   cmp_vld_ff;
   logic [IDX_W-1:0]       cmp_idx_ff;
   logic [KEY_W-1:0]       rd_key_ff;

   logic                   match_found_ff;
   logic [IDX_W-1:0]       match_idx_ff;
   logic                   free_found_ff;
   logic [IDX_W-1:0]       free_idx_ff;

   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   logic                   issue;
   logic                   match_now;
   logic                   free_now;
   logic                   last_now;
   logic                   full;

   rsp_type                rsp_in;
   logic                   do_write;
   logic [IDX_W-1:0]       wr_idx;
   logic                   append;
   logic                   clr_valid;
   logic                   clear_all;
   logic                   insert_path;

   assign issue     = cmd.step && (addr_ff < count_ff);
   assign match_now = cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_key_ff == key_ff);
   assign free_now  = cmp_vld_ff && !valid_ff[cmp_idx_ff];
   assign last_now  = cmp_vld_ff && (CNT_W'(cmp_idx_ff) == (count_ff - CNT_W'(1)));
   assign full      = (count_ff == CNT_W'(TABLE_DEPTH));

   always_comb begin
      stat.scan_done = (op_ff == OP_CLR) || (count_ff == '0) || last_now
                    || (match_now && ((op_ff == OP_GET) || (op_ff == OP_DEL)))
                    || (free_now && (op_ff == OP_ADD));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op_type'(req_data.operation);
         key_ff <= req_data.key;
      end
      if (issue) begin
         rd_key_ff <= mem[addr_ff[IDX_W-1:0]];
      end
      cmp_idx_ff <= addr_ff[IDX_W-1:0];
      if (cmd.step && match_now && !match_found_ff) begin
         match_idx_ff <= cmp_idx_ff;
      end
      if (cmd.step && free_now && !free_found_ff) begin
         free_idx_ff <= cmp_idx_ff;
      end
      if (cmd.commit) begin
         rsp_data_ff <= rsp_in;
      end
      if (cmd.commit && do_write) begin
         mem[wr_idx] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff        <= '0;
         cmp_vld_ff     <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
      end else if (cmd.load) begin
         addr_ff        <= '0;
         cmp_vld_ff     <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
      end else begin
         cmp_vld_ff <= issue;
         if (issue) begin
            addr_ff <= addr_ff + CNT_W'(1);
         end
         if (cmd.step && match_now) begin
            match_found_ff <= 1'b1;
         end
         if (cmd.step && free_now) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   // commit decision from the latched scan results
   always_comb begin
      rsp_in.slot   = '0;
      rsp_in.hit    = 1'b0;
      rsp_in.status = ST_OK;
      do_write      = 1'b0;
      wr_idx        = free_idx_ff;
      append        = 1'b0;
      clr_valid     = 1'b0;
      clear_all     = 1'b0;
      insert_path   = 1'b0;
      case (op_ff)
         OP_GET: begin
            if (match_found_ff) begin
               rsp_in.slot = SLOT_W'(match_idx_ff);
               rsp_in.hit  = 1'b1;
            end else begin
               insert_path = 1'b1;
            end
         end
         OP_ADD: begin
            insert_path = 1'b1;
         end
         OP_DEL: begin
            if (match_found_ff) begin
               clr_valid   = 1'b1;
               rsp_in.slot = SLOT_W'(match_idx_ff);
               rsp_in.hit  = 1'b1;
            end else begin
               rsp_in.status = ST_NOTFOUND;
            end
         end
         OP_CLR: begin
            clear_all = 1'b1;
         end
         default: begin
            clear_all = 1'b0;
         end
      endcase
      if (insert_path) begin
         if (free_found_ff) begin
            do_write    = 1'b1;
            wr_idx      = free_idx_ff;
            rsp_in.slot = SLOT_W'(free_idx_ff);
         end else if (!full) begin
            do_write    = 1'b1;
            append      = 1'b1;
            wr_idx      = count_ff[IDX_W-1:0];
            rsp_in.slot = SLOT_W'(count_ff[IDX_W-1:0]);
         end else begin
            rsp_in.status = ST_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
         if (cmd.commit) begin
            if (clear_all) begin
               valid_ff <= '0;
               count_ff <= '0;
            end
            if (do_write) begin
               valid_ff[wr_idx] <= 1'b1;
            end
            if (clr_valid) begin
               valid_ff[match_idx_ff] <= 1'b0;
            end
            if (append) begin
               count_ff <= count_ff + CNT_W'(1);
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/key_slot_table.sv -----
// ----------------------------------------------------------------------------
// key_slot_table
// associative table of 16-bit keys with free slot reuse and a high-water count
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one result follows
// for every request, shown for a single cycle with rsp_valid high. The
// receiver cannot stall, so it must take each result in that cycle. The
// table is scanned up to the high-water entry count (0 to 64), one entry per
// cycle through the single read port of the key memory, then a commit state
// applies the update. The scan stops early at the first match for
// get-or-insert and delete, and at the first free slot for add. Clear, and
// any request on an empty table, end the scan at once. busy drops in the
// cycle the result is shown, so the next request can be taken there. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module key_slot_table (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  kst_pkg::req_type req_data,
   output logic             rsp_valid,
   output kst_pkg::rsp_type rsp_data
);
   import kst_pkg::*;

   // command and status between sequencer and datapath
   kst_cmd_type  cmd;
   kst_stat_type stat;

   // sequencer: idle, scan the entries below the count, commit
   kst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // key memory, valid bits, count and the registered result transfer
   kst_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/core/kst_checker.sv -----
// ----------------------------------------------------------------------------
// kst_checker
// port level checks of the key slot table
// ----------------------------------------------------------------------------
`default_nettype none

module kst_checker (
   input wire              clock,
   input wire              reset,
   input wire              start,
   input wire              busy,
   input kst_pkg::req_type req_data,
   input wire              rsp_valid,
   input kst_pkg::rsp_type rsp_data
);
   import kst_pkg::*;

   logic unused_req;
   assign unused_req = ^req_data;

   // an accepted request always occupies the block for a scan
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // result transfer lasts one cycle only
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // busy ends exactly when the result is shown
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // delete miss reports no slot and no hit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_NOTFOUND))
         |-> (!rsp_data.hit && (rsp_data.slot == '0)))
      else $error("delete miss with slot or hit set");

   // a hit is always a clean result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |-> (rsp_data.status == ST_OK))
      else $error("hit with error status");

endmodule

bind key_slot_table kst_checker u_kst_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
